// ----- hw/rtl/kir_pkg.sv -----
`timescale 1ns / 1ps

package kir_pkg;

    // Fixed port widths of the block.
    localparam int DATA_W     = 32;
    localparam int CFG_W      = 6;
    localparam int CFG_ADDR_W = 2;

    // Configuration register indexes.
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_NUM_COMPONENTS  = 2'd0,
        CFG_THRESHOLD_COUNT = 2'd1,
        CFG_COUNT_FAILURES  = 2'd2
    } t_cfg_idx;

endpackage

// ----- hw/rtl/kir_mul.sv -----
`timescale 1ns / 1ps

module kir_mul #(
    parameter int FRACTION_BITS = 31
) (
    input  logic                         i_clk,
    input  logic [FRACTION_BITS:0]       i_a,
    input  logic [FRACTION_BITS:0]       i_b,
    output logic [2*FRACTION_BITS+1:0]   o_p,
    output logic [FRACTION_BITS:0]       o_fx
);

    localparam int OPW = FRACTION_BITS + 1;
    localparam int PW  = 2 * OPW;

    logic [PW-1:0] r_p;
    logic [PW-1:0] rnd;

    always_ff @(posedge i_clk) begin
        r_p <= PW'(i_a) * PW'(i_b);
    end

    // Fixed-point product, rounded half up.
    assign rnd  = r_p + (PW'(1) << (FRACTION_BITS - 1));
    assign o_p  = r_p;
    assign o_fx = rnd[FRACTION_BITS +: OPW];

endmodule

// ----- hw/rtl/kir_coef_gen.sv -----
`timescale 1ns / 1ps

module kir_coef_gen #(
    parameter int MAX_COMPONENTS = 32,
    parameter int FRACTION_BITS  = 31
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [$clog2(MAX_COMPONENTS+1)-1:0] i_rows,
    output logic                               o_done,
    input  logic                               i_rd_en,
    input  logic [$clog2(MAX_COMPONENTS+1)-1:0] i_rd_addr,
    output logic [FRACTION_BITS+1:0]           o_rd_data
);

    localparam int AW    = $clog2(MAX_COMPONENTS + 1);
    localparam int DEPTH = MAX_COMPONENTS + 1;
    localparam int CFW   = FRACTION_BITS + 2;
    localparam logic [CFW-1:0] CAP = {1'b1, {(FRACTION_BITS + 1){1'b0}}};

    // Coefficients are kept saturated at CAP; only whether they reach one matters above that.
    logic [CFW-1:0] mem [DEPTH];
    logic [CFW-1:0] r_rd_data;

    logic           r_busy;
    logic           r_done;
    logic [AW-1:0]  r_row;
    logic [AW:0]    r_col;
    logic           r_pend;
    logic [AW-1:0]  r_pcol;
    logic [CFW-1:0] r_prev;

    logic           rd_issue;
    logic           rd_en;
    logic [AW-1:0]  rd_addr;
    logic           last_col;
    logic [CFW-1:0] old_val;
    logic [CFW:0]   add;
    logic [CFW-1:0] wr_data;

    assign rd_issue = r_busy && (r_col <= {1'b0, r_row});
    assign rd_en    = rd_issue || i_rd_en;
    assign rd_addr  = r_busy ? r_col[AW-1:0] : i_rd_addr;
    assign last_col = (r_pcol == r_row);

    // The entry at the row index is new in this row and reads as zero.
    assign old_val = last_col ? '0 : r_rd_data;
    assign add     = {1'b0, old_val} + {1'b0, r_prev};
    assign wr_data = (add > {1'b0, CAP}) ? CAP : add[CFW-1:0];

    always_ff @(posedge i_clk) begin
        if (r_busy && r_pend) begin
            mem[r_pcol] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_pend <= 1'b0;
            r_row  <= '0;
            r_col  <= '0;
            r_pcol <= '0;
            r_prev <= '0;
        end else begin
            r_done <= !i_start && r_busy && r_pend && last_col && (r_row == i_rows);
            if (i_start) begin
                r_busy <= 1'b1;
                r_pend <= 1'b0;
                r_row  <= AW'(1);
                r_col  <= (AW+1)'(1);
                r_prev <= CFW'(1);
            end else if (r_busy) begin
                r_pend <= rd_issue;
                r_pcol <= r_col[AW-1:0];
                if (rd_issue) begin
                    r_col <= r_col + (AW+1)'(1);
                end
                if (r_pend) begin
                    if (!last_col) begin
                        r_prev <= old_val;
                    end else if (r_row == i_rows) begin
                        r_busy <= 1'b0;
                    end else begin
                        r_row  <= r_row + AW'(1);
                        r_col  <= (AW+1)'(1);
                        r_prev <= CFW'(1);
                    end
                end
            end
        end
    end

    assign o_done    = r_done;
    assign o_rd_data = r_rd_data;

endmodule

// ----- hw/rtl/koon_identical_reliability.sv -----
// The coefficient row is built first, then each fixed-point multiply runs in turn on
// the shared multiplier.
// Throughput: one item at a time; the input is not ready until the result is registered.
// A finished result waits in the output register while the next item is worked on.
// Reset (synchronous, active low) returns n = 2, k = 1, success mode and the idle state.
`timescale 1ns / 1ps

module koon_identical_reliability #(
    parameter int MAX_COMPONENTS = 32,
    parameter int FRACTION_BITS  = 31
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [kir_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [kir_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [kir_pkg::DATA_W-1:0]    i_component_reliability,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [kir_pkg::DATA_W-1:0]    o_system_reliability
);

    localparam int OPW = FRACTION_BITS + 1;
    localparam int PW  = 2 * OPW;
    localparam int AW  = $clog2(MAX_COMPONENTS + 1);
    localparam int CFW = FRACTION_BITS + 2;
    localparam logic [OPW-1:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE,
        S_PAS,
        S_PRE,
        S_PRE_W,
        S_TERM,
        S_POW,
        S_POW_W,
        S_COEF,
        S_TERM_W,
        S_NEXT,
        S_ADV_W,
        S_DONE
    } t_state;

    t_state r_state;

    logic [kir_pkg::CFG_W-1:0] r_num;
    logic [kir_pkg::CFG_W-1:0] r_thr;
    logic                      r_mode;

    logic [OPW-1:0]           r_first;
    logic [OPW-1:0]           r_second;
    logic [OPW-1:0]           r_pre;
    logic [OPW-1:0]           r_p;
    logic [AW-1:0]            r_cnt;
    logic [AW-1:0]            r_w;
    logic [FRACTION_BITS-1:0] r_sum;
    logic                     r_flag;
    logic                     r_out_valid;
    logic [OPW-1:0]           r_out;

    logic [AW-1:0]  eff_count;
    logic           empty_sum;
    logic [OPW-1:0] rel_clamped;
    logic           in_acc;
    logic           gen_start;
    logic           gen_done;
    logic           coef_rd;
    logic [CFW-1:0] gen_data;
    logic [CFW-1:0] coef;
    logic [OPW-1:0] mul_a;
    logic [OPW-1:0] mul_b;
    logic [PW-1:0]  mul_p;
    logic [OPW-1:0] mul_fx;
    logic [OPW-1:0] n_sum;
    logic [OPW-1:0] sum_c;
    logic [OPW-1:0] res;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num  <= kir_pkg::CFG_W'(2);
            r_thr  <= kir_pkg::CFG_W'(1);
            r_mode <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                kir_pkg::CFG_NUM_COMPONENTS:  r_num  <= i_cfg_wdata;
                kir_pkg::CFG_THRESHOLD_COUNT: r_thr  <= i_cfg_wdata;
                kir_pkg::CFG_COUNT_FAILURES:  r_mode <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign eff_count = ({1'b0, r_num} > 7'(MAX_COMPONENTS)) ? AW'(MAX_COMPONENTS)
                                                             : AW'(r_num);
    assign empty_sum = ({1'b0, r_thr} > 7'(eff_count));
    assign rel_clamped = (i_component_reliability > kir_pkg::DATA_W'(ONE)) ?
                         ONE : i_component_reliability[OPW-1:0];

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign gen_start  = in_acc && !empty_sum && (eff_count != '0);
    assign coef_rd    = (r_state == S_TERM);

    kir_coef_gen #(
        .MAX_COMPONENTS (MAX_COMPONENTS),
        .FRACTION_BITS  (FRACTION_BITS)
    ) u_coef_gen (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (gen_start),
        .i_rows    (eff_count),
        .o_done    (gen_done),
        .i_rd_en   (coef_rd),
        .i_rd_addr (r_w),
        .o_rd_data (gen_data)
    );

    // C(n,0) is one and is not stored.
    assign coef = (r_w == '0) ? CFW'(1) : gen_data;

    always_comb begin
        unique case (r_state)
            S_POW: begin
                mul_a = r_p;
                mul_b = r_second;
            end
            S_COEF: begin
                mul_a = coef[OPW-1:0];
                mul_b = r_p;
            end
            default: begin
                mul_a = r_pre;
                mul_b = r_first;
            end
        endcase
    end

    kir_mul #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p),
        .o_fx  (mul_fx)
    );

    assign n_sum = {1'b0, r_sum} + {1'b0, mul_p[FRACTION_BITS-1:0]};
    assign sum_c = r_flag ? ONE : {1'b0, r_sum};
    assign res   = r_mode ? (ONE - sum_c) : sum_c;

    // r_pre holds first^w; r_p walks through the remaining n-w factors of second.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_flag      <= 1'b0;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_w         <= '0;
        end else begin
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_first  <= r_mode ? (ONE - rel_clamped) : rel_clamped;
                        r_second <= r_mode ? rel_clamped : (ONE - rel_clamped);
                        r_pre    <= ONE;
                        r_sum    <= '0;
                        r_flag   <= 1'b0;
                        r_cnt    <= '0;
                        r_w      <= AW'(r_thr);
                        if (empty_sum) begin
                            r_state <= S_DONE;
                        end else if (eff_count != '0) begin
                            r_state <= S_PAS;
                        end else begin
                            r_state <= S_PRE;
                        end
                    end
                end
                S_PAS: begin
                    if (gen_done) begin
                        r_state <= S_PRE;
                    end
                end
                S_PRE: begin
                    r_state <= (r_cnt < r_w) ? S_PRE_W : S_TERM;
                end
                S_PRE_W: begin
                    r_pre   <= mul_fx;
                    r_cnt   <= r_cnt + AW'(1);
                    r_state <= S_PRE;
                end
                S_TERM: begin
                    r_p     <= r_pre;
                    r_cnt   <= r_w;
                    r_state <= S_POW;
                end
                S_POW: begin
                    r_state <= (r_cnt < eff_count) ? S_POW_W : S_COEF;
                end
                S_POW_W: begin
                    r_p     <= mul_fx;
                    r_cnt   <= r_cnt + AW'(1);
                    r_state <= S_POW;
                end
                S_COEF: begin
                    if (r_p == '0) begin
                        r_state <= S_NEXT;
                    end else if (coef >= CFW'(ONE)) begin
                        // One term already reaches one, so the clamped sum is one.
                        r_flag  <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_TERM_W;
                    end
                end
                S_TERM_W: begin
                    if (mul_p >= PW'(ONE) || n_sum >= ONE) begin
                        r_flag  <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_sum   <= n_sum[FRACTION_BITS-1:0];
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    if (r_w == eff_count) begin
                        r_state <= S_DONE;
                    end else begin
                        r_w     <= r_w + AW'(1);
                        r_state <= S_ADV_W;
                    end
                end
                S_ADV_W: begin
                    r_pre   <= mul_fx;
                    r_state <= S_TERM;
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out       <= res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_system_reliability = kir_pkg::DATA_W'(r_out);

endmodule

// ----- hw/rtl/kir_checker.sv -----
`timescale 1ns / 1ps

module kir_checker #(
    parameter int FRACTION_BITS = 31
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [kir_pkg::DATA_W-1:0]    o_system_reliability
);

    localparam logic [kir_pkg::DATA_W-1:0] ONE = kir_pkg::DATA_W'(1) << FRACTION_BITS;

    // A result that is not taken stays, unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_system_reliability)))
        else $error("result dropped or changed while stalled");

    // Every result is a probability.
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_system_reliability <= ONE))
        else $error("result above one");

    // An accepted item keeps the block busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready right after an accepted item");

    // A new result only appears at the end of work on an item.
    a_out_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result appeared while the block was idle");

endmodule

bind koon_identical_reliability kir_checker #(
    .FRACTION_BITS (FRACTION_BITS)
) u_kir_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_in_valid           (i_in_valid),
    .o_in_ready           (o_in_ready),
    .o_out_valid          (o_out_valid),
    .i_out_ready          (i_out_ready),
    .o_system_reliability (o_system_reliability)
);

// ----- verif/tb_koon_identical_reliability.sv -----
`timescale 1ns / 1ps

module tb_koon_identical_reliability;

    localparam int MAX_COMPONENTS = 32;
    localparam int FRACTION_BITS  = 31;
    localparam logic [63:0] FIXED_ONE  = 64'd1 << FRACTION_BITS;
    localparam logic [63:0] FIXED_HALF = 64'd1 << (FRACTION_BITS - 1);
    localparam logic [kir_pkg::DATA_W-1:0] REL_ONE = FIXED_ONE[kir_pkg::DATA_W-1:0];

    // Index 3 has no register behind it; writes there must be dropped.
    localparam logic [kir_pkg::CFG_ADDR_W-1:0] CFG_UNMAPPED = 2'd3;

    localparam int READY_ALWAYS = 0;
    localparam int READY_RANDOM = 1;
    localparam int READY_LONG   = 2;

    localparam int IDLE_LIMIT   = 40000;
    localparam int DRAIN_CYCLES = 3000;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_we = 1'b0;
    logic [kir_pkg::CFG_ADDR_W-1:0] i_cfg_addr = kir_pkg::CFG_NUM_COMPONENTS;
    logic [kir_pkg::CFG_W-1:0]      i_cfg_wdata = '0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_ready;
    logic [kir_pkg::DATA_W-1:0]     i_component_reliability = '0;
    logic                           o_out_valid;
    logic                           i_out_ready = 1'b1;
    logic [kir_pkg::DATA_W-1:0]     o_system_reliability;

    // Local copy of the configuration registers.
    logic [kir_pkg::CFG_W-1:0] cfg_components = 6'd2;
    logic [kir_pkg::CFG_W-1:0] cfg_threshold  = 6'd1;
    logic                      cfg_failures   = 1'b0;

    logic [kir_pkg::DATA_W-1:0] expected_reliability[$];
    int mismatch_count = 0;
    int idle_cycles = 0;
    int ready_mode = READY_ALWAYS;
    int stall_left = 0;
    int burst_left = 0;
    bit gaps_on = 1'b0;

    koon_identical_reliability #(
        .MAX_COMPONENTS(MAX_COMPONENTS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_top (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg_we               (i_cfg_we),
        .i_cfg_addr             (i_cfg_addr),
        .i_cfg_wdata            (i_cfg_wdata),
        .i_in_valid             (i_in_valid),
        .o_in_ready             (o_in_ready),
        .i_component_reliability(i_component_reliability),
        .o_out_valid            (o_out_valid),
        .i_out_ready            (i_out_ready),
        .o_system_reliability   (o_system_reliability)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [63:0] fixed_mul(input logic [63:0] a, input logic [63:0] b);
        return (a * b + FIXED_HALF) >> FRACTION_BITS;
    endfunction

    // Binomial k-out-of-n reliability for the current register settings.
    function automatic logic [kir_pkg::DATA_W-1:0] predict_system_reliability(
        input logic [kir_pkg::DATA_W-1:0] r_raw);
        logic [63:0]  pascal [0:MAX_COMPONENTS];
        logic [63:0]  r, u, first_base, second_base, prod, term, total;
        logic [127:0] wide;
        logic [64:0]  acc;
        int n, k, i, j, w;
        r = {32'd0, r_raw};
        if (r > FIXED_ONE) r = FIXED_ONE;
        u = FIXED_ONE - r;
        n = (cfg_components > MAX_COMPONENTS) ? MAX_COMPONENTS : int'(cfg_components);
        k = int'(cfg_threshold);
        pascal[0] = 64'd1;
        for (i = 1; i <= n; i++) begin
            pascal[i] = 64'd1;
            for (j = i - 1; j >= 1; j--) pascal[j] = pascal[j] + pascal[j - 1];
        end
        first_base  = cfg_failures ? u : r;
        second_base = cfg_failures ? r : u;
        total = 64'd0;
        for (w = k; w <= n; w++) begin
            prod = FIXED_ONE;
            for (j = 0; j < w; j++) prod = fixed_mul(prod, first_base);
            for (j = w; j < n; j++) prod = fixed_mul(prod, second_base);
            wide = {64'd0, pascal[w]} * {64'd0, prod};
            term = (wide[127:64] != 0) ? '1 : wide[63:0];
            acc = {1'b0, total} + {1'b0, term};
            total = acc[64] ? '1 : acc[63:0];
        end
        if (total > FIXED_ONE) total = FIXED_ONE;
        if (cfg_failures) total = FIXED_ONE - total;
        return total[kir_pkg::DATA_W-1:0];
    endfunction

    function automatic logic [kir_pkg::DATA_W-1:0] random_reliability();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll < 14) return $urandom_range(0, REL_ONE);
        if (roll < 17) begin
            case ($urandom_range(0, 4))
                0: return '0;
                1: return 32'd1;
                2: return REL_ONE - 1;
                3: return REL_ONE;
                default: return REL_ONE + 1;
            endcase
        end
        return $urandom();
    endfunction

    // Receiver: always ready, randomly ready, or long stalls now and then.
    always @(posedge i_clk) begin
        case (ready_mode)
            READY_ALWAYS: i_out_ready <= 1'b1;
            READY_RANDOM: i_out_ready <= ($urandom_range(0, 2) != 0);
            default: begin
                if (stall_left > 0) begin
                    stall_left <= stall_left - 1;
                    i_out_ready <= 1'b0;
                end else begin
                    i_out_ready <= 1'b1;
                    if ($urandom_range(0, 7) == 0) stall_left <= $urandom_range(1, 300);
                end
            end
        endcase
    end

    always @(posedge i_clk) begin
        logic [kir_pkg::DATA_W-1:0] want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_reliability.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected item, system_reliability %h",
                         $time, o_system_reliability);
            end else begin
                want = expected_reliability.pop_front();
                if (o_system_reliability !== want) begin
                    mismatch_count++;
                    $display("%0t: system_reliability expected %h actual %h",
                             $time, want, o_system_reliability);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Called at a rising edge; returns at the edge where the item was taken,
    // leaving valid high so a following item can go out back to back.
    task automatic send_reliability(input logic [kir_pkg::DATA_W-1:0] value);
        int gap;
        if (gaps_on && burst_left == 0) begin
            gap = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 8) : $urandom_range(9, 300);
            burst_left = $urandom_range(1, 6);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        if (burst_left > 0) burst_left--;
        i_in_valid <= 1'b1;
        i_component_reliability <= value;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        expected_reliability.push_back(predict_system_reliability(value));
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_reliability.size() != 0);
    endtask

    task automatic write_register(input logic [kir_pkg::CFG_ADDR_W-1:0] idx,
                                  input logic [kir_pkg::CFG_W-1:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        case (idx)
            kir_pkg::CFG_NUM_COMPONENTS:  cfg_components = value;
            kir_pkg::CFG_THRESHOLD_COUNT: cfg_threshold = value;
            kir_pkg::CFG_COUNT_FAILURES:  cfg_failures = value[0];
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_config(input logic [kir_pkg::CFG_W-1:0] n,
                                input logic [kir_pkg::CFG_W-1:0] k,
                                input logic fail_mode);
        wait_for_results();
        write_register(kir_pkg::CFG_NUM_COMPONENTS, n);
        write_register(kir_pkg::CFG_THRESHOLD_COUNT, k);
        write_register(kir_pkg::CFG_COUNT_FAILURES, {5'd0, fail_mode});
    endtask

    // Reset settings: two components, one needed, success mode.
    task automatic test_reset_defaults();
        gaps_on = 1'b0;
        send_reliability('0);
        send_reliability(REL_ONE);
        send_reliability(REL_ONE >> 1);
        send_reliability('1);
        send_reliability(32'd1);
        send_reliability(REL_ONE - 1);
    endtask

    task automatic test_directed_corners();
        apply_config(6'd32, 6'd1, 1'b0);
        send_reliability(REL_ONE >> 1);
        // More components than the block holds, threshold equal to the count.
        apply_config(6'd63, 6'd32, 1'b1);
        send_reliability(32'h7FFF_FFFF);
        // No components and a zero threshold.
        apply_config(6'd0, 6'd0, 1'b0);
        send_reliability(32'h1234_5678);
        apply_config(6'd0, 6'd0, 1'b1);
        send_reliability(32'h1234_5678);
        apply_config(6'd5, 6'd0, 1'b0);
        send_reliability(REL_ONE >> 2);
        apply_config(6'd5, 6'd0, 1'b1);
        send_reliability(REL_ONE >> 2);
        // Threshold above the component count leaves the sum empty.
        apply_config(6'd4, 6'd5, 1'b0);
        send_reliability(REL_ONE >> 1);
        apply_config(6'd4, 6'd63, 1'b1);
        send_reliability(REL_ONE >> 1);
        apply_config(6'd1, 6'd1, 1'b0);
        send_reliability('0);
        send_reliability(REL_ONE);
        apply_config(6'd7, 6'd3, 1'b1);
        send_reliability(32'h5555_5555);
        send_reliability(32'h2AAA_AAAA);
        send_reliability(32'hAAAA_AAAA);
    endtask

    task automatic test_unmapped_register();
        apply_config(6'd3, 6'd2, 1'b0);
        write_register(CFG_UNMAPPED, 6'h3F);
        send_reliability(32'h2AAA_AAAB);
    endtask

    task automatic test_random_phases();
        logic [kir_pkg::CFG_W-1:0] n, k;
        int roll, items, phase, i;
        for (phase = 0; phase < 24; phase++) begin
            roll = $urandom_range(0, 9);
            if (roll < 7) n = kir_pkg::CFG_W'($urandom_range(1, 8));
            else if (roll == 7) n = kir_pkg::CFG_W'($urandom_range(9, 16));
            else n = kir_pkg::CFG_W'($urandom_range(0, 63));
            k = (roll < 8) ? kir_pkg::CFG_W'($urandom_range(0, int'(n) + 1))
                           : kir_pkg::CFG_W'($urandom_range(0, 63));
            apply_config(n, k, 1'($urandom_range(0, 1)));
            // Large component counts are slow, so only a few items use them.
            items = (n > 16) ? 3 : 25;
            gaps_on = (phase % 4 != 0);
            ready_mode <= (phase % 4 == 0) ? READY_ALWAYS
                                           : $urandom_range(READY_RANDOM, READY_LONG);
            for (i = 0; i < items; i++) begin
                if ($urandom_range(0, 39) == 0) wait_for_results();
                send_reliability(random_reliability());
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_directed_corners();
        test_unmapped_register();
        test_random_phases();
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_reliability.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/kir_pkg.sv
hw/rtl/kir_mul.sv
hw/rtl/kir_coef_gen.sv
hw/rtl/koon_identical_reliability.sv
hw/rtl/kir_checker.sv
verif/tb_koon_identical_reliability.sv
